// File: hdl/dtl_pkg.sv
// dtl_pkg: shared types and constants for the diagonal tent landscape block
// request and response words, register indexes and fixed-point widths
package dtl_pkg;

    localparam int VAL_W   = 24;
    localparam int THETA_W = 16;
    localparam int COORD_W = 6;
    localparam int LVL_W   = 2;
    localparam int KCFG_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [VAL_W-1:0]  STEP_RESET = 24'd4096;
    localparam logic [VAL_W:0]    S_SAT      = 25'h100_0000;
    localparam logic [KCFG_W-1:0] K_RESET    = 3'd1;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_COMMIT = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req_type;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THETA_THRESHOLD = 2'd0,
        CFG_GRID_STEP       = 2'd1,
        CFG_K_IN_USE        = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_READ,
        S_WALK
    } t_state;

    typedef struct packed {
        t_req_type                 req_type;
        logic [COORD_W-1:0]        grid_x;
        logic [COORD_W-1:0]        grid_y;
        logic [LVL_W-1:0]          level;
        logic signed [THETA_W-1:0] bar_theta;
        logic [VAL_W-1:0]          bar_length;
    } t_req;

    typedef struct packed {
        logic [VAL_W-1:0] cell_value;
    } t_rsp;

endpackage

// File: hdl/dtl_req_if.sv
// dtl_req_if: valid/ready channel carrying one request word
// depends on dtl_pkg for the t_req payload type
interface dtl_req_if;
    import dtl_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/dtl_rsp_if.sv
// dtl_rsp_if: valid/ready channel carrying one response word
// depends on dtl_pkg for the t_rsp payload type
interface dtl_rsp_if;
    import dtl_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/diagonal_tent_landscape.sv
// diagonal_tent_landscape: k-level tent landscapes kept in one on-chip memory
// depends on dtl_pkg, dtl_req_if and dtl_rsp_if
//
// An add-bar word is finished when it is taken, so the next word can follow. A
// read word holds the input in S_READ until the output register is free; its
// result is then loaded into that register, and further words are taken while
// that result waits. A commit with nothing to walk only empties the candidate
// list. Any other commit runs one read-modify-write per diagonal cell of each
// kept rank, at most min(GRID_W, GRID_H) cells per rank, writing back only where
// the tent value is larger, and takes no word until the walk ends. After reset
// and after each clear word the memory is zeroed by a clearing pass over all
// 2**(clog2(MAX_LEVELS)+clog2(GRID_W)+clog2(GRID_H)) words (16384 by default),
// during which no word is taken. Configuration writes are taken at any time.
module diagonal_tent_landscape #(
    parameter int GRID_W     = 64,
    parameter int GRID_H     = 64,
    parameter int MAX_LEVELS = 4
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_we,
    input  logic [dtl_pkg::CFG_IDX_W-1:0]                 i_cfg_idx,
    input  logic [dtl_pkg::CFG_DATA_W-1:0]                i_cfg_data,
    dtl_req_if.sink                                       i_req,
    dtl_rsp_if.source                                     o_rsp
);
    import dtl_pkg::*;

    localparam int XW  = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int YW  = (GRID_H > 1) ? $clog2(GRID_H) : 1;
    localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int AW  = LW + XW + YW;
    localparam int XC  = ((XW > COORD_W) ? XW : COORD_W) + 1;
    localparam int YC  = ((YW > COORD_W) ? YW : COORD_W) + 1;
    localparam int LV  = ((LW > LVL_W) ? LW : LVL_W) + 1;
    localparam int CW  = LW + 1;
    localparam int KX  = (CW > KCFG_W) ? CW : KCFG_W;
    localparam int DEPTH = 1 << AW;

    // landscape memory
    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;
    logic [AW-1:0]    w_raddr;
    logic [AW-1:0]    w_waddr;
    logic [VAL_W-1:0] w_wdata;
    logic             w_we;

    // configuration
    logic signed [THETA_W-1:0] r_thr;
    logic [VAL_W-1:0]          r_step;
    logic [KCFG_W-1:0]         r_k;

    // control and walk state
    t_state           r_state, n_state;
    logic [AW-1:0]    r_sweep, n_sweep;
    logic [CW-1:0]    r_rank, n_rank;
    logic [CW-1:0]    r_levels, n_levels;
    logic [XC-1:0]    r_cx, n_cx, r_x0, n_x0;
    logic [YC-1:0]    r_cy, n_cy, r_y0, n_y0;
    logic [VAL_W:0]   r_s, n_s;
    logic             r_tnz, n_tnz;
    logic [VAL_W-1:0] r_top [MAX_LEVELS];
    logic [VAL_W-1:0] n_top [MAX_LEVELS];
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_wb_valid, n_wb_valid;
    logic [AW-1:0]    r_wb_addr, n_wb_addr;
    logic [VAL_W-1:0] r_wb_v, n_wb_v;
    logic [AW-1:0]    r_rd_addr, n_rd_addr;
    logic             r_rd_zero, n_rd_zero;
    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_out_data, n_out_data;

    // request decode
    t_req             w_req;
    logic             w_acc;
    logic [XC-1:0]    w_x;
    logic [YC-1:0]    w_y;
    logic [LV-1:0]    w_lvl;
    logic             w_in_grid;
    logic [AW-1:0]    w_req_addr;

    // bar insertion
    logic [MAX_LEVELS-1:0] w_ge;
    logic [CW-1:0]         w_pos;
    logic                  w_take;
    logic [VAL_W-1:0]      w_ins [MAX_LEVELS];

    // commit level count
    logic [KX-1:0] w_kx, w_ksat, w_cntx, w_lvls;

    // tent value
    logic [VAL_W-1:0] w_len;
    logic [VAL_W+1:0] w_two_s;
    logic [VAL_W+1:0] w_ssum;
    logic [VAL_W-1:0] w_v;
    logic [XC-1:0]    w_nx;
    logic [YC-1:0]    w_ny;
    logic             w_end_rank;
    logic [AW-1:0]    w_walk_addr;

    assign w_req = i_req.data;
    assign i_req.ready = (r_state == S_IDLE) && !r_wb_valid;
    assign w_acc = i_req.valid && i_req.ready;

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data.cell_value = r_out_data;

    assign w_x = XC'(w_req.grid_x);
    assign w_y = YC'(w_req.grid_y);
    assign w_lvl = LV'(w_req.level);
    assign w_in_grid = (w_x < XC'(GRID_W)) && (w_y < YC'(GRID_H));
    assign w_req_addr = {w_lvl[LW-1:0], w_x[XW-1:0], w_y[YW-1:0]};

    // insertion point of an offered bar in the descending list
    always_comb begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
            w_ge[i] = (CW'(i) < r_cnt) && (r_top[i] >= w_req.bar_length);
        end
        w_pos = CW'($countones(w_ge));
        w_take = (w_req.bar_theta >= r_thr) && (w_pos < CW'(MAX_LEVELS));
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (CW'(i) < w_pos) begin
                w_ins[i] = r_top[i];
            end else if (CW'(i) == w_pos) begin
                w_ins[i] = w_req.bar_length;
            end else begin
                w_ins[i] = r_top[(i > 0) ? i - 1 : 0];
            end
        end
    end

    // levels = min(top count, k clamped to 1..MAX_LEVELS)
    always_comb begin
        w_kx = KX'(r_k);
        if (w_kx == '0) begin
            w_ksat = KX'(1);
        end else if (w_kx > KX'(MAX_LEVELS)) begin
            w_ksat = KX'(MAX_LEVELS);
        end else begin
            w_ksat = w_kx;
        end
        w_cntx = KX'(r_cnt);
        w_lvls = (w_cntx < w_ksat) ? w_cntx : w_ksat;
    end

    // tent value at the current walk cell
    always_comb begin
        w_len = r_top[r_rank[LW-1:0]];
        w_two_s = {r_s, 1'b0};
        if (w_two_s <= {2'b00, w_len}) begin
            w_v = r_s[VAL_W-1:0];
        end else if ({1'b0, w_len} > r_s) begin
            w_v = w_len - r_s[VAL_W-1:0];
        end else begin
            w_v = '0;
        end
        w_ssum = {1'b0, r_s} + {2'b00, r_step};
        w_nx = r_cx + XC'(1);
        w_ny = r_cy + YC'(1);
        w_end_rank = (r_tnz && (w_v == '0)) || (w_nx >= XC'(GRID_W))
                     || (w_ny >= YC'(GRID_H));
        w_walk_addr = {r_rank[LW-1:0], r_cx[XW-1:0], r_cy[YW-1:0]};
    end

    // next state and datapath control
    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        n_rank = r_rank;
        n_levels = r_levels;
        n_cx = r_cx;
        n_cy = r_cy;
        n_x0 = r_x0;
        n_y0 = r_y0;
        n_s = r_s;
        n_tnz = r_tnz;
        n_top = r_top;
        n_cnt = r_cnt;
        n_wb_valid = 1'b0;
        n_wb_addr = r_wb_addr;
        n_wb_v = r_wb_v;
        n_rd_addr = r_rd_addr;
        n_rd_zero = r_rd_zero;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_data = r_out_data;
        w_raddr = w_req_addr;

        case (r_state)
            S_SWEEP: begin
                n_sweep = r_sweep + AW'(1);
                if (r_sweep == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    case (w_req.req_type)
                        REQ_ADD: begin
                            if (w_take) begin
                                n_top = w_ins;
                                if (r_cnt < CW'(MAX_LEVELS)) begin
                                    n_cnt = r_cnt + CW'(1);
                                end
                            end
                        end
                        REQ_COMMIT: begin
                            if (w_in_grid && (w_lvls != '0)) begin
                                n_state = S_WALK;
                                n_levels = CW'(w_lvls);
                                n_rank = '0;
                                n_x0 = w_x;
                                n_y0 = w_y;
                                n_cx = w_x;
                                n_cy = w_y;
                                n_s = '0;
                                n_tnz = 1'b0;
                            end else begin
                                for (int i = 0; i < MAX_LEVELS; i++) begin
                                    n_top[i] = '0;
                                end
                                n_cnt = '0;
                            end
                        end
                        REQ_READ: begin
                            n_state = S_READ;
                            n_rd_addr = w_req_addr;
                            n_rd_zero = !w_in_grid || (w_lvl >= LV'(MAX_LEVELS));
                        end
                        REQ_CLEAR: begin
                            n_state = S_SWEEP;
                            n_sweep = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                w_raddr = r_rd_addr;
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data = r_rd_zero ? '0 : r_rdata;
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                w_raddr = w_walk_addr;
                n_wb_valid = 1'b1;
                n_wb_addr = w_walk_addr;
                n_wb_v = w_v;
                n_tnz = 1'b1;
                n_cx = w_nx;
                n_cy = w_ny;
                n_s = (w_ssum >= {1'b0, S_SAT}) ? S_SAT : w_ssum[VAL_W:0];
                if (w_end_rank) begin
                    n_cx = r_x0;
                    n_cy = r_y0;
                    n_s = '0;
                    n_tnz = 1'b0;
                    n_rank = r_rank + CW'(1);
                    if (r_rank + CW'(1) >= r_levels) begin
                        n_state = S_IDLE;
                        for (int i = 0; i < MAX_LEVELS; i++) begin
                            n_top[i] = '0;
                        end
                        n_cnt = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // write port: clearing pass or raise-to-max write-back
    always_comb begin
        if (r_state == S_SWEEP) begin
            w_we = 1'b1;
            w_waddr = r_sweep;
            w_wdata = '0;
        end else begin
            w_we = r_wb_valid && (r_wb_v > r_rdata);
            w_waddr = r_wb_addr;
            w_wdata = r_wb_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
            r_step <= STEP_RESET;
            r_k <= K_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_THETA_THRESHOLD: r_thr <= i_cfg_data[THETA_W-1:0];
                CFG_GRID_STEP:       r_step <= i_cfg_data[VAL_W-1:0];
                CFG_K_IN_USE:        r_k <= i_cfg_data[KCFG_W-1:0];
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_sweep <= '0;
            r_cnt <= '0;
            r_wb_valid <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_top[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_cnt <= n_cnt;
            r_wb_valid <= n_wb_valid;
            r_out_valid <= n_out_valid;
            r_top <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank <= n_rank;
        r_levels <= n_levels;
        r_cx <= n_cx;
        r_cy <= n_cy;
        r_x0 <= n_x0;
        r_y0 <= n_y0;
        r_s <= n_s;
        r_tnz <= n_tnz;
        r_wb_addr <= n_wb_addr;
        r_wb_v <= n_wb_v;
        r_rd_addr <= n_rd_addr;
        r_rd_zero <= n_rd_zero;
        r_out_data <= n_out_data;
    end

    a_wb_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_valid |-> $past(r_state) == S_WALK)
        else $error("write-back without a walk step");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_LEVELS))
        else $error("candidate count above level count");

    a_commit_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (w_req.req_type == REQ_COMMIT) |=> (r_cnt == '0) || (r_state == S_WALK))
        else $error("commit left candidates without walking");

    a_read_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (w_req.req_type == REQ_READ) |=> r_state == S_READ)
        else $error("read word not followed by data phase");

endmodule
